### rtl/parity_checked_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the parity-checked frame receiver
// Shorthand for concurrent assertions clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PARITY_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define PARITY_CHECKED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Check on every rising edge, skip while reset is asserted.
`define PCFR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define PCFR_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pcfr_pkg.sv
// ----------------------------------------------------------------------------
// Parity-checked frame receiver package
// Widths, bit patterns, status codes and the parity check shared by the block.
// ----------------------------------------------------------------------------
package pcfr_pkg;

	localparam int unsigned COUNT_W   = 32;
	localparam int unsigned WINDOW_W  = 4;
	localparam int unsigned FRAME_BITS = 11;
	localparam int unsigned TAKEN_W   = 4;
	localparam int unsigned DATA_W    = 8;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [WINDOW_W-1:0] END_PATTERN   = 4'b1011;
	localparam logic [WINDOW_W-1:0] START_PATTERN = 4'b1101;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_END    = 2'd0,
		STATUS_OK     = 2'd1,
		STATUS_PARITY = 2'd2
	} status_t;

	typedef logic [FRAME_BITS-1:0] payload_t;

	// Data bits 0..7, parity bits 8..10 over {0,3,6}, {1,4,7}, {2,5}.
	function automatic logic parity_ok(input payload_t p);
		logic p0;
		logic p1;
		logic p2;
		p0 = p[0] ^ p[3] ^ p[6];
		p1 = p[1] ^ p[4] ^ p[7];
		p2 = p[2] ^ p[5];
		return (p0 == p[8]) && (p1 == p[9]) && (p2 == p[10]);
	endfunction

endpackage

### rtl/pcfr_if.sv
// ----------------------------------------------------------------------------
// Parity-checked frame receiver channels
// Valid/ready channels for samples, results and the threshold register.
// ----------------------------------------------------------------------------
interface pcfr_sample_if;
	logic                           valid;
	logic                           ready;
	logic [pcfr_pkg::COUNT_W-1:0]   sample_count;

	modport source (output valid, output sample_count, input ready);
	modport sink   (input valid, input sample_count, output ready);
endinterface

interface pcfr_result_if;
	logic                           valid;
	logic                           ready;
	logic [pcfr_pkg::STATUS_W-1:0]  status;
	logic [pcfr_pkg::DATA_W-1:0]    data_byte;

	modport source (output valid, output status, output data_byte, input ready);
	modport sink   (input valid, input status, input data_byte, output ready);
endinterface

interface pcfr_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [pcfr_pkg::COUNT_W-1:0]   bit_threshold;

	modport source (output valid, output bit_threshold, input ready);
	modport sink   (input valid, input bit_threshold, output ready);
endinterface

### rtl/parity_checked_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// Parity-checked frame receiver
// Slices activity counts into bits, hunts for start/end patterns and checks
// the parity of each 11-bit frame.
// ----------------------------------------------------------------------------
//
//  channel  | modport | payload                 | transaction
//  ---------+---------+-------------------------+--------------------------
//  sample   | sink    | sample_count[31:0]      | one sampling period
//  result   | source  | status[1:0], data_byte  | end sequence / frame / error
//  cfg      | sink    | bit_threshold[31:0]     | threshold write
//
//  One sample per cycle sustained unless a result is held back. A sample enters
//  the input register, is decoded and applied to the receiver state as it leaves,
//  and its result (if any) is loaded into the output register at the same time.
//  The threshold compare plus the window/frame update is the only logic
//  between the two registers. sample.ready drops only while the input register
//  is full and a result is held back by result.ready. cfg.ready is always
//  high. Reset clears the threshold, all receiver state and both valid flags.
//
module parity_checked_frame_receiver_unit (
	input  logic                clk,
	input  logic                arst_n,
	pcfr_sample_if.sink         sample,
	pcfr_result_if.source       result,
	pcfr_cfg_if.sink            cfg
);

	// Threshold register
	logic [pcfr_pkg::COUNT_W-1:0]  threshold_q;

	// Input register
	logic                          valid_s1;
	logic [pcfr_pkg::COUNT_W-1:0]  count_s1;

	// Receiver state
	logic [pcfr_pkg::WINDOW_W-1:0] window_q;
	logic                          in_frame_q;
	logic [pcfr_pkg::TAKEN_W-1:0]  taken_q;
	pcfr_pkg::payload_t            payload_q;

	// Output register
	logic                          out_valid_q;
	pcfr_pkg::status_t             out_status_q;
	logic [pcfr_pkg::DATA_W-1:0]   out_data_q;

	// Next-state and result logic
	logic                          rx_bit;
	logic                          out_free;
	logic                          advance;
	logic [pcfr_pkg::WINDOW_W-1:0] window_shift;
	pcfr_pkg::payload_t            payload_ins;
	logic                          frame_done;
	logic [pcfr_pkg::WINDOW_W-1:0] window_d;
	logic                          in_frame_d;
	logic [pcfr_pkg::TAKEN_W-1:0]  taken_d;
	pcfr_pkg::payload_t            payload_d;
	logic                          emit;
	pcfr_pkg::status_t             status_d;
	logic [pcfr_pkg::DATA_W-1:0]   data_d;

	// Output register frees up when empty or being drained this cycle.
	assign out_free  = !out_valid_q || result.ready;
	// Input register moves on whenever the output side can take its result.
	assign advance   = valid_s1 && out_free;
	assign sample.ready = !valid_s1 || out_free;
	assign cfg.ready = 1'b1;

	assign result.valid     = out_valid_q;
	assign result.status    = out_status_q;
	assign result.data_byte = out_data_q;

	// Counts strictly below the threshold decode as one.
	assign rx_bit       = count_s1 < threshold_q;
	assign window_shift = {window_q[pcfr_pkg::WINDOW_W-2:0], rx_bit};
	assign payload_ins  = payload_q | (pcfr_pkg::payload_t'(rx_bit) << taken_q);
	assign frame_done   = taken_q == pcfr_pkg::TAKEN_W'(pcfr_pkg::FRAME_BITS - 1);

	always_comb begin
		window_d   = window_q;
		in_frame_d = in_frame_q;
		taken_d    = taken_q;
		payload_d  = payload_q;
		emit       = 1'b0;
		status_d   = pcfr_pkg::STATUS_END;
		data_d     = '0;
		if (!in_frame_q) begin
			// Hunting: shift the bit in and look for either pattern.
			priority if (window_shift == pcfr_pkg::END_PATTERN) begin
				window_d = '0;
				emit     = 1'b1;
			end else if (window_shift == pcfr_pkg::START_PATTERN) begin
				// Window freezes for the length of the frame.
				window_d   = window_shift;
				in_frame_d = 1'b1;
				taken_d    = '0;
				payload_d  = '0;
			end else begin
				window_d = window_shift;
			end
		end else if (frame_done) begin
			// Last frame bit: report, then drop all state and hunt again.
			emit       = 1'b1;
			window_d   = '0;
			in_frame_d = 1'b0;
			taken_d    = '0;
			payload_d  = '0;
			if (pcfr_pkg::parity_ok(payload_ins)) begin
				status_d = pcfr_pkg::STATUS_OK;
				data_d   = payload_ins[pcfr_pkg::DATA_W-1:0];
			end else begin
				status_d = pcfr_pkg::STATUS_PARITY;
			end
		end else begin
			// Collect the bit, LSB first.
			payload_d = payload_ins;
			taken_d   = taken_q + 1'b1;
		end
	end

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg.valid) begin
			threshold_q <= cfg.bit_threshold;
		end
	end

	// Input register: load on every accepted sample, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			count_s1 <= sample.sample_count;
		end
	end

	// Receiver state advances once per sample that leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			in_frame_q <= 1'b0;
			taken_q    <= '0;
			payload_q  <= '0;
		end else if (advance) begin
			window_q   <= window_d;
			in_frame_q <= in_frame_d;
			taken_q    <= taken_d;
			payload_q  <= payload_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_status_q <= status_d;
			out_data_q   <= data_d;
		end
	end

endmodule

### rtl/pcfr_checker.sv
// ----------------------------------------------------------------------------
// Parity-checked frame receiver checker
// Port-level checks on the handshakes and result encoding, bound to the top.
// ----------------------------------------------------------------------------
`include "parity_checked_frame_receiver_unit_assert.svh"

module pcfr_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [pcfr_pkg::STATUS_W-1:0]  out_status,
	input  logic [pcfr_pkg::DATA_W-1:0]    out_data
);

	// No result may be pending while reset is applied.
	`PCFR_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result valid in reset")

	// Input may only stall behind a blocked result.
	`PCFR_ASSERT(a_stall_cause, in_valid && !in_ready |-> out_valid && !out_ready, "input stalled without blocked result")

	// Data byte is zero unless the frame passed its parity check.
	`PCFR_ASSERT(a_data_zero, out_valid && (out_status != pcfr_pkg::STATUS_OK) |-> out_data == '0, "data byte set on non-ok status")

	// A blocked result holds.
	`PCFR_ASSERT(a_result_hold, out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_data), "stalled result changed")

endmodule

bind parity_checked_frame_receiver_unit pcfr_checker u_pcfr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_data   (result.data_byte)
);
